@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the line fold RTL; they expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high
`define LFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line fold check failed");

// Next-cycle implication, ignored while reset is high
`define LFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line fold check failed");

`endif

@@ rtl/core/lfc_pkg.sv @@
// Shared types, constants and the microcode table of the line fold block.
`timescale 1ns / 1ps

package lfc_pkg;

  localparam int CHAR_W = 8;
  localparam int FOLD_W = 6;
  localparam int MAX_WIDTH_DEF = 32;
  localparam logic [FOLD_W-1:0] FOLD_WIDTH_RST = 6'd9;

  localparam logic [CHAR_W-1:0] NL_CHAR = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;
  localparam logic [CHAR_W-1:0] TAB_CHAR = 8'd9;

  // Microprogram step address
  typedef logic [1:0] upc_t;
  localparam upc_t UPC_IDLE = 2'd0;
  localparam upc_t UPC_EMIT = 2'd1;
  localparam upc_t UPC_NL = 2'd2;

  // Jump condition select
  typedef enum logic [1:0] {
    COND_FOLD    = 2'd0,
    COND_RD_DONE = 2'd1,
    COND_NL_SENT = 2'd2
  } cond_sel_t;

  // One control word
  typedef struct packed {
    logic      in_take;
    logic      rd_en;
    logic      nl_en;
    cond_sel_t cond;
    upc_t      target;
  } uword_t;

  // Status flags from the datapath to the sequencer
  typedef struct packed {
    logic fold_start;
    logic rd_done;
    logic nl_sent;
  } seq_cond_t;

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == SPACE_CHAR) || (c == TAB_CHAR);
  endfunction

  // Control store: wait on the condition, then jump to target
  function automatic uword_t ucode_rom(input upc_t pc);
    uword_t w;
    w = '0;
    unique case (pc)
      UPC_IDLE: begin
        w.in_take = 1'b1;
        w.cond = COND_FOLD;
        w.target = UPC_EMIT;
      end
      UPC_EMIT: begin
        w.rd_en = 1'b1;
        w.cond = COND_RD_DONE;
        w.target = UPC_NL;
      end
      UPC_NL: begin
        w.nl_en = 1'b1;
        w.cond = COND_NL_SENT;
        w.target = UPC_IDLE;
      end
      default: begin
        w.cond = COND_NL_SENT;
        w.target = UPC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/lfc_useq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps

module lfc_useq
  import lfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  seq_cond_t cond,
  output uword_t    ctl
);

  upc_t pc;
  upc_t pc_next;
  logic hit;

  assign ctl = ucode_rom(pc);

  // Evaluate the selected jump condition
  always_comb begin
    case (ctl.cond)
      COND_FOLD:    hit = cond.fold_start;
      COND_RD_DONE: hit = cond.rd_done;
      COND_NL_SENT: hit = cond.nl_sent;
      default:      hit = 1'b1;
    endcase
    pc_next = hit ? ctl.target : pc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= UPC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

@@ rtl/core/line_fold_at_column_unit.sv @@
// Top level of the line fold block: segment buffer, emit datapath and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Greedy word-wrap line folder for a byte stream.
// Input channel: in_valid / in_stall / char_in, one text byte per item.
// Output channel: out_valid / out_stall / char_out / last; last marks the final
// byte produced for one input item. Folded segments end with a newline byte.
// Config: fold_width_we writes fold_width (0 acts as 1, above MAX_WIDTH acts as
// MAX_WIDTH); write it only while the block is idle.
// A byte that simply appends produces nothing.
// A newline or a byte arriving at a full buffer emits n buffered bytes and a
// newline, paced by the one-byte-per-cycle read port of the segment buffer
// (while the output does not stall) and by the microcode steps (accept, read
// loop, newline).
// After accept, the first emitted byte passes the read stage and then the output
// register while the output is free.
// The buffer is circular; a fold moves its head pointer instead of copying.
// Reset empties the buffer (length zero), restores fold_width to 9 and clears
// both valid flags; no clearing pass is needed. A stall on the output holds
// the output register and the read stage; the input is taken again as soon as
// the last newline of the previous item sits in the output register.
// A final line without a newline is never emitted.

module line_fold_at_column_unit
  import lfc_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fold_width_we,
  input  logic [FOLD_W-1:0] fold_width,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] char_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] char_out,
  output logic              last
);

  localparam int LW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [LW:0] MAX_EXT = (LW + 1)'(MAX_WIDTH);

  // Logical buffer index to memory address, wrapping once
  function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] b,
                                              input logic [LW-1:0] idx);
    logic [LW:0] s;
    s = (LW + 1)'(b) + (LW + 1)'(idx);
    if (s >= MAX_EXT) begin
      s = s - MAX_EXT;
    end
    return AW'(s);
  endfunction

  uword_t    ctl;
  seq_cond_t cond;

  lfc_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .ctl  (ctl)
  );

  logic [CHAR_W-1:0] mem [MAX_WIDTH];

  logic [FOLD_W-1:0] width_cfg;
  logic [LW-1:0]     len;
  logic [AW-1:0]     base;
  logic              has_blank;
  logic              tail_blank;
  logic [LW-1:0]     blank_pos;

  logic [CHAR_W-1:0] cmd_char;
  logic              cmd_nl;
  logic [LW-1:0]     emit_n;
  logic [LW-1:0]     cmd_keep;
  logic [AW-1:0]     cmd_base;

  logic [LW-1:0]     rd_idx;
  logic              rd_valid;
  logic [CHAR_W-1:0] rdata;

  logic [FOLD_W-1:0] eff6;
  logic [LW-1:0]     eff;
  logic              in_fire;
  logic              in_nl;
  logic              full;
  logic              split;
  logic              fold_start;
  logic              out_free;
  logic              rd_move;
  logic              rd_issue;
  logic              rd_done;
  logic              nl_push;
  logic              app_en;
  logic [LW-1:0]     app_idx;
  logic [AW-1:0]     app_addr;
  logic [CHAR_W-1:0] app_char;

  // Effective fold width and the fold decision for the arriving byte
  always_comb begin
    if (width_cfg == '0) begin
      eff6 = FOLD_W'(1);
    end else if (width_cfg > FOLD_W'(MAX_WIDTH)) begin
      eff6 = FOLD_W'(MAX_WIDTH);
    end else begin
      eff6 = width_cfg;
    end
    eff = LW'(eff6);
  end

  assign in_stall   = !ctl.in_take;
  assign in_fire    = in_valid && ctl.in_take;
  assign in_nl      = (char_in == NL_CHAR);
  assign full       = (len >= eff);
  // not a newline, buffer full, last char not blank and an earlier blank exists
  assign split      = !in_nl && full && !tail_blank && has_blank;
  assign fold_start = in_fire && (in_nl || full);

  // Emit pipeline: read stage feeds output register
  assign out_free = !out_valid || !out_stall;
  assign rd_move  = rd_valid && out_free;
  assign rd_issue = ctl.rd_en && (rd_idx != emit_n) && (!rd_valid || rd_move);
  assign rd_done  = ctl.rd_en && (rd_idx == emit_n);
  assign nl_push  = ctl.nl_en && !rd_valid && out_free;

  assign cond = '{fold_start: fold_start, rd_done: rd_done, nl_sent: nl_push};

  // Append port: plain append at accept, or held byte after a fold
  always_comb begin
    if (ctl.in_take) begin
      app_en   = in_fire && !in_nl && !full;
      app_idx  = len;
      app_addr = phys_addr(base, len);
      app_char = char_in;
    end else begin
      app_en   = nl_push && !cmd_nl;
      app_idx  = cmd_keep;
      app_addr = phys_addr(cmd_base, cmd_keep);
      app_char = cmd_char;
    end
  end

  // Segment buffer memory
  always_ff @(posedge clk) begin
    if (app_en) begin
      mem[app_addr] <= app_char;
    end
    if (rd_issue) begin
      rdata <= mem[phys_addr(base, rd_idx)];
    end
  end

  // Latch the fold command
  always_ff @(posedge clk) begin
    if (fold_start) begin
      cmd_char <= char_in;
      cmd_nl   <= in_nl;
      if (split) begin
        emit_n   <= blank_pos;
        cmd_keep <= len - blank_pos - LW'(1);
        cmd_base <= phys_addr(base, blank_pos + LW'(1));
      end else begin
        emit_n   <= len;
        cmd_keep <= '0;
        cmd_base <= '0;
      end
    end
  end

  // Buffer bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg  <= FOLD_WIDTH_RST;
      len        <= '0;
      base       <= '0;
      has_blank  <= 1'b0;
      tail_blank <= 1'b0;
    end else begin
      if (fold_width_we) begin
        width_cfg <= fold_width;
      end
      if (nl_push) begin
        base      <= cmd_nl ? '0 : cmd_base;
        len       <= '0;
        has_blank <= 1'b0;
        tail_blank <= 1'b0;
      end
      if (app_en) begin
        len <= app_idx + LW'(1);
        if (is_blank(app_char)) begin
          has_blank  <= 1'b1;
          tail_blank <= 1'b1;
        end else begin
          tail_blank <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (app_en && is_blank(app_char)) begin
      blank_pos <= app_idx;
    end
  end

  // Read index and read stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      rd_idx   <= '0;
    end else begin
      if (fold_start) begin
        rd_idx <= '0;
      end else if (rd_issue) begin
        rd_idx <= rd_idx + LW'(1);
      end
      if (rd_issue) begin
        rd_valid <= 1'b1;
      end else if (rd_move) begin
        rd_valid <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_move || nl_push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_move) begin
      char_out <= rdata;
      last     <= 1'b0;
    end else if (nl_push) begin
      char_out <= NL_CHAR;
      last     <= 1'b1;
    end
  end

  // Checks
  `LFC_ASSERT_NOW(a_take_with_pipe_empty, in_fire, !rd_valid)
  `LFC_ASSERT_NOW(a_len_bounded, 1'b1, len <= LW'(MAX_WIDTH))
  `LFC_ASSERT_NOW(a_rd_idx_bounded, ctl.rd_en, rd_idx <= emit_n)
  `LFC_ASSERT_NEXT(a_nl_ends_item, nl_push, out_valid && last && (char_out == NL_CHAR))

endmodule
